[rtl/tpe_pkg.sv]
package tpe_pkg;

  // Polynomial shape and number formats.
  localparam int unsigned MAX_ORDER = 7;
  localparam int unsigned NSLOT     = MAX_ORDER + 1;
  localparam int unsigned NAXIS     = 3;
  localparam int unsigned DEPTH     = NAXIS * NSLOT;
  localparam int unsigned SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int unsigned Q_W       = 48;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned HALF_W    = Q_W / 2;
  localparam int unsigned ORD_W     = 3;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // Register stages inside one fixed-point multiplier.
  localparam int unsigned QMUL_LAT  = 3;

  localparam logic [Q_W-1:0] Q_ONE   = {{(Q_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};
  localparam logic [Q_W-1:0] Q_ROUND = {{(Q_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
  localparam logic signed [Q_W-1:0] QMAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] QMIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic {
    OP_EVAL  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_OFFSET = 2'd0,
    REG_ORDER_X     = 2'd1,
    REG_ORDER_Y     = 2'd2,
    REG_ORDER_Z     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    op_t                     operation;
    logic signed [Q_W-1:0]   time_value;
    logic [IDX_W-1:0]        coeff_index;
    logic signed [Q_W-1:0]   coeff_value;
  } cmd_t;

  typedef struct packed {
    logic signed [Q_W-1:0] pos_x;
    logic signed [Q_W-1:0] pos_y;
    logic signed [Q_W-1:0] pos_z;
    logic                  index_error;
    logic                  overflow;
  } result_t;

  // Sign-magnitude value; neg is set only for nonzero negative values.
  typedef struct packed {
    logic           neg;
    logic [Q_W-1:0] mag;
  } sm_t;

endpackage

[rtl/three_axis_poly_eval.sv]
// Throughput: one item per cycle; busy is low whenever rst is low and the receiver cannot stall.
// Most of the depth is the chain of six Q24.24 multipliers (three stages each) that forms dt^7.
// Reset: synchronous active-high rst clears the configuration registers, the coefficient store
// and all pipeline valid bits; busy is held high and cfg_ready low while rst is high.
module three_axis_poly_eval import tpe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cmd_t                 cmd,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [Q_W-1:0]       cfg_data,
  output logic                 done,
  output result_t              result
);

  // Pipeline geometry. Stage 0 registers the command, stage 1 holds dt, then each power of
  // dt takes one multiplier latency. At stage T_P all powers are present and the coefficient
  // store is read; the term products land at T_T; an adder tree of LV levels follows, and the
  // output register is loaded from stage T_O-1.
  localparam int unsigned QLAT   = QMUL_LAT;
  localparam int unsigned PLINKS = (MAX_ORDER > 1) ? MAX_ORDER - 1 : 0;
  localparam int unsigned T_P    = 1 + QLAT * PLINKS;
  localparam int unsigned T_T    = T_P + QLAT;
  localparam int unsigned LV     = (NSLOT > 1) ? $clog2(NSLOT) : 0;
  localparam int unsigned TN     = 1 << LV;
  localparam int unsigned SW     = Q_W + LV;
  localparam int unsigned T_O    = T_T + 2 + LV;
  localparam int unsigned RES_LAT = T_O + 1;
  localparam int unsigned EO_W   = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int unsigned CALC_W = $clog2(DEPTH + (1 << IDX_W)) + 1;

  // Side information that travels with each item through the whole pipeline.
  typedef struct packed {
    op_t               op;
    logic              err;
    logic [SLOT_W-1:0] slot;
    sm_t               coeff;
    logic              ov;
  } side_t;

  // All powers of dt, plus the overflow seen so far while forming them.
  typedef struct packed {
    logic              ov;
    sm_t [MAX_ORDER:0] pw;
  } pvec_t;

  function automatic logic [EO_W-1:0] eff_order(input logic [ORD_W-1:0] o);
    return (int'(o) > int'(MAX_ORDER)) ? EO_W'(MAX_ORDER) : EO_W'(o);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Configuration registers, unguarded: the user must change them only with the pipeline empty.
  // ---------------------------------------------------------------------------------------
  logic signed [Q_W-1:0] time_offset;
  logic [ORD_W-1:0]      order_x;
  logic [ORD_W-1:0]      order_y;
  logic [ORD_W-1:0]      order_z;

  assign cfg_ready = !rst;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_offset <= '0;
      order_x     <= '0;
      order_y     <= '0;
      order_z     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TIME_OFFSET: time_offset <= cfg_data;
        REG_ORDER_X:     order_x     <= cfg_data[ORD_W-1:0];
        REG_ORDER_Y:     order_y     <= cfg_data[ORD_W-1:0];
        REG_ORDER_Z:     order_z     <= cfg_data[ORD_W-1:0];
        default: ;
      endcase
    end
  end

  logic [EO_W-1:0] ord_eff [NAXIS];
  logic [EO_W-1:0] top_ord;

  always_comb begin
    ord_eff[0] = eff_order(order_x);
    ord_eff[1] = eff_order(order_y);
    ord_eff[2] = eff_order(order_z);
    top_ord    = ord_eff[0];
    if (ord_eff[1] > top_ord) top_ord = ord_eff[1];
    if (ord_eff[2] > top_ord) top_ord = ord_eff[2];
  end

  // ---------------------------------------------------------------------------------------
  // Stage 0: accept the command. For a write beat the flat index is mapped to its per-axis
  // slot with the orders in force, and the coefficient is turned into sign-magnitude form,
  // which is how the store keeps it.
  // ---------------------------------------------------------------------------------------
  logic                 accept;
  logic [CALC_W-1:0]    n_idx;
  logic [CALC_W-1:0]    nx;
  logic [CALC_W-1:0]    ny;
  logic [CALC_W-1:0]    nz;
  logic [CALC_W-1:0]    slot_c;
  logic                 err_c;
  logic [Q_W-1:0]       cmag_c;

  assign accept = start && !busy;

  always_comb begin
    n_idx = CALC_W'(cmd.coeff_index);
    nx    = CALC_W'(ord_eff[0]) + CALC_W'(1);
    ny    = CALC_W'(ord_eff[1]) + CALC_W'(1);
    nz    = CALC_W'(ord_eff[2]) + CALC_W'(1);
    err_c = n_idx >= (nx + ny + nz);
    if (n_idx < nx) begin
      slot_c = n_idx;
    end else if (n_idx < nx + ny) begin
      slot_c = CALC_W'(NSLOT) + (n_idx - nx);
    end else begin
      slot_c = CALC_W'(2 * NSLOT) + (n_idx - nx - ny);
    end
    cmag_c = cmd.coeff_value[Q_W-1] ? (~cmd.coeff_value + 1'b1) : cmd.coeff_value;
  end

  logic                  sbv [0:T_O-1];
  side_t                 sb  [0:T_O-1];
  side_t                 sb_in [1:T_O-1];
  logic signed [Q_W-1:0] t0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < T_O; i++) sbv[i] <= 1'b0;
    end else begin
      sbv[0] <= accept;
      for (int i = 1; i < T_O; i++) sbv[i] <= sbv[i-1];
    end
  end

  logic  term_ov;
  pvec_t vec [0:PLINKS];

  always_comb begin
    for (int i = 1; i < T_O; i++) sb_in[i] = sb[i-1];
    // Power overflow joins the item once all powers are formed; term overflow joins it in the
    // side register that follows the term products.
    sb_in[T_P+1].ov = vec[PLINKS].ov;
    sb_in[T_T+1].ov = sb[T_T].ov | term_ov;
  end

  always_ff @(posedge clk) begin
    sb[0].op        <= cmd.operation;
    sb[0].err       <= err_c;
    sb[0].slot      <= slot_c[SLOT_W-1:0];
    sb[0].coeff.neg <= cmd.coeff_value[Q_W-1];
    sb[0].coeff.mag <= cmag_c;
    sb[0].ov        <= 1'b0;
    t0              <= cmd.time_value;
    for (int i = 1; i < T_O; i++) sb[i] <= sb_in[i];
  end

  // ---------------------------------------------------------------------------------------
  // Stage 1: dt = time - offset, kept as sign and magnitude. Both differences are formed in
  // parallel so no negation follows the subtraction; the result saturates to 48 bits.
  // ---------------------------------------------------------------------------------------
  logic [Q_W:0] dpos;
  logic [Q_W:0] dneg;
  logic [Q_W:0] dmag;
  logic [Q_W:0] dlim;
  logic         dsgn;
  sm_t          dt;
  logic         dt_ov;

  always_comb begin
    dpos = {t0[Q_W-1], t0} - {time_offset[Q_W-1], time_offset};
    dneg = {time_offset[Q_W-1], time_offset} - {t0[Q_W-1], t0};
    dsgn = dpos[Q_W];
    dmag = dsgn ? dneg : dpos;
    dlim = dsgn ? {1'b0, QMIN} : {1'b0, QMAX};
  end

  always_ff @(posedge clk) begin
    dt.neg <= dsgn;
    dt.mag <= (dmag > dlim) ? dlim[Q_W-1:0] : dmag[Q_W-1:0];
    dt_ov  <= dmag > dlim;
  end

  // ---------------------------------------------------------------------------------------
  // Power chain. vec[0] holds 1.0 and dt; link j multiplies dt^j by dt to give dt^(j+1)
  // while the vector gathered so far is delayed alongside the multiplier. A saturation in
  // a power counts only if that power is needed by some axis.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    vec[0]        = '0;
    vec[0].ov     = dt_ov;
    vec[0].pw[0]  = '{neg: 1'b0, mag: Q_ONE};
    for (int k = 1; k < int'(NSLOT) && k < 2; k++) vec[0].pw[k] = dt;
  end

  for (genvar j = 1; j <= PLINKS; j++) begin : g_pow
    pvec_t dl [QLAT];
    sm_t   pj;
    logic  pj_ov;

    tpe_qmul u_qmul (
      .clk (clk),
      .a   (vec[j-1].pw[j]),
      .b   (vec[j-1].pw[1]),
      .p   (pj),
      .ov  (pj_ov)
    );

    always_ff @(posedge clk) begin
      dl[0] <= vec[j-1];
      for (int i = 1; i < int'(QLAT); i++) dl[i] <= dl[i-1];
    end

    always_comb begin
      vec[j]         = dl[QLAT-1];
      vec[j].pw[j+1] = pj;
      vec[j].ov      = dl[QLAT-1].ov | (pj_ov && ((j + 1) <= int'(top_ord)));
    end
  end

  // ---------------------------------------------------------------------------------------
  // Coefficient store, in sign-magnitude form. Writes happen at stage T_P, the same stage
  // where evaluations read it, so every item sees exactly the writes issued before it.
  // ---------------------------------------------------------------------------------------
  sm_t store [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(DEPTH); i++) store[i] <= '0;
    end else if (sbv[T_P] && (sb[T_P].op == OP_WRITE) && !sb[T_P].err) begin
      store[sb[T_P].slot] <= sb[T_P].coeff;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Term products: one multiplier per coefficient slot; slot k of every axis takes dt^k.
  // ---------------------------------------------------------------------------------------
  sm_t  tm    [NAXIS][NSLOT];
  logic tm_ov [NAXIS][NSLOT];

  for (genvar a = 0; a < NAXIS; a++) begin : g_axis
    for (genvar k = 0; k < NSLOT; k++) begin : g_term
      tpe_qmul u_qmul (
        .clk (clk),
        .a   (store[a*NSLOT+k]),
        .b   (vec[PLINKS].pw[k]),
        .p   (tm[a][k]),
        .ov  (tm_ov[a][k])
      );
    end
  end

  // Terms above an axis's order are dropped, together with any overflow they raised.
  logic [Q_W-1:0] term_v [NAXIS][NSLOT];

  always_comb begin
    term_ov = 1'b0;
    for (int a = 0; a < int'(NAXIS); a++) begin
      for (int k = 0; k < int'(NSLOT); k++) begin
        term_v[a][k] = tm[a][k].neg ? (~tm[a][k].mag + 1'b1) : tm[a][k].mag;
        term_ov      = term_ov | (tm_ov[a][k] && (k <= int'(ord_eff[a])));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Adder tree, heap ordered: node n has children 2n+1 and 2n+2, leaves sit from TN-1 on.
  // Every node is a register, and the root holds the exact sum of the leaves.
  // ---------------------------------------------------------------------------------------
  logic signed [SW-1:0] tree [NAXIS][2*TN-1];

  always_ff @(posedge clk) begin
    for (int a = 0; a < int'(NAXIS); a++) begin
      for (int k = 0; k < int'(NSLOT); k++) begin
        tree[a][TN-1+k] <= (k <= int'(ord_eff[a])) ? SW'($signed(term_v[a][k])) : '0;
      end
      for (int k = NSLOT; k < int'(TN); k++) tree[a][TN-1+k] <= '0;
      for (int n = 0; n < int'(TN) - 1; n++) begin
        tree[a][n] <= tree[a][2*n+1] + tree[a][2*n+2];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output register: saturate each sum, assemble the result beat. Write beats carry only
  // the index error flag.
  // ---------------------------------------------------------------------------------------
  logic signed [Q_W-1:0] pos_c [NAXIS];
  logic                  sum_ov;
  result_t               res_c;

  always_comb begin
    sum_ov = 1'b0;
    for (int a = 0; a < int'(NAXIS); a++) begin
      if (tree[a][0] > SW'(QMAX)) begin
        pos_c[a] = QMAX;
        sum_ov   = 1'b1;
      end else if (tree[a][0] < SW'(QMIN)) begin
        pos_c[a] = QMIN;
        sum_ov   = 1'b1;
      end else begin
        pos_c[a] = tree[a][0][Q_W-1:0];
      end
    end
    res_c = '0;
    if (sb[T_O-1].op == OP_WRITE) begin
      res_c.index_error = sb[T_O-1].err;
    end else begin
      res_c.pos_x    = pos_c[0];
      res_c.pos_y    = pos_c[1];
      res_c.pos_z    = pos_c[2];
      res_c.overflow = sb[T_O-1].ov | sum_ov;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sbv[T_O-1];
    end
    result <= res_c;
  end

`ifndef NO_ASSERTIONS
  // Every accepted beat comes out after the fixed pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(RES_LAT) done)
    else $error("accepted beat did not produce a result at the expected cycle");

  // No result beat appears without a beat accepted the pipeline latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, RES_LAT))
    else $error("result beat without a matching accepted beat");

  // An index error belongs to a write beat, which carries no positions and no overflow.
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    done && result.index_error |->
      result.pos_x == '0 && result.pos_y == '0 && result.pos_z == '0 && !result.overflow)
    else $error("write result carries evaluation data");

  // A saturated dt must reach the overflow flag of its evaluation result.
  a_dt_ov: assert property (@(posedge clk) disable iff (rst)
    sbv[1] && (sb[1].op == OP_EVAL) && dt_ov |-> ##(T_O-1) done && result.overflow)
    else $error("dt saturation lost before the result");
`endif

endmodule

[rtl/tpe_qmul.sv]
module tpe_qmul import tpe_pkg::*; (
  input  logic clk,
  input  sm_t  a,
  input  sm_t  b,
  output sm_t  p,
  output logic ov
);

  localparam int unsigned PP_W   = 2 * HALF_W;
  localparam int unsigned PROD_W = 2 * Q_W;
  localparam int unsigned QT_W   = PROD_W - FRAC_W;

  logic [PP_W-1:0]   pp_ll;
  logic [PP_W-1:0]   pp_lh;
  logic [PP_W-1:0]   pp_hl;
  logic [PP_W-1:0]   pp_hh;
  logic              neg1;
  logic [PROD_W-1:0] prod;
  logic              neg2;
  logic [QT_W-1:0]   q;
  logic [Q_W-1:0]    limit;
  logic              big;
  logic [Q_W-1:0]    mag_c;

  // First stage: four half-width partial products of the magnitudes.
  always_ff @(posedge clk) begin
    pp_ll <= a.mag[HALF_W-1:0]   * b.mag[HALF_W-1:0];
    pp_lh <= a.mag[HALF_W-1:0]   * b.mag[Q_W-1:HALF_W];
    pp_hl <= a.mag[Q_W-1:HALF_W] * b.mag[HALF_W-1:0];
    pp_hh <= a.mag[Q_W-1:HALF_W] * b.mag[Q_W-1:HALF_W];
    neg1  <= a.neg ^ b.neg;
  end

  // Second stage: full product with the half-LSB rounding term added.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(pp_ll)
          + (PROD_W'(pp_lh) << HALF_W)
          + (PROD_W'(pp_hl) << HALF_W)
          + (PROD_W'(pp_hh) << (2 * HALF_W))
          + PROD_W'(Q_ROUND);
    neg2 <= neg1;
  end

  // Third stage: drop the fraction bits and clamp to the signed range.
  always_comb begin
    q     = prod[PROD_W-1:FRAC_W];
    limit = neg2 ? QMIN : QMAX;
    big   = (q[QT_W-1:Q_W] != '0) || (q[Q_W-1:0] > limit);
    mag_c = big ? limit : q[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    p.mag <= mag_c;
    p.neg <= neg2 && (mag_c != '0);
    ov    <= big;
  end

endmodule
